@@ rtl/core/lpe_pkg.sv @@
// ----------------------------------------------------------------------------
// Lehmer permutation encoder package
// Shared widths, the tree memory word and helpers for the Fenwick walks.
// ----------------------------------------------------------------------------
package lpe_pkg;

  localparam int MAX_ELEMENTS = 4096;
  localparam int ADDR_W       = $clog2(MAX_ELEMENTS);   // element and memory address
  localparam int CNT_W        = ADDR_W + 1;             // sizes and tree counts
  localparam int IDX_W        = ADDR_W + 2;             // update walk index may overshoot
  localparam int EPOCH_W      = 8;
  localparam int CFG_W        = 13;

  localparam logic [7:0] VARINT_CONT = 8'h80;
  localparam logic [6:0] VARINT_LOW7 = 7'h7F;

  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [CNT_W-1:0]   cnt_t;
  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [EPOCH_W-1:0] epoch_t;

  // One memory word: tree node (address + 1) and used flag of value (address).
  typedef struct packed {
    epoch_t epoch;
    logic   used;
    cnt_t   cnt;
  } ent_t;

  typedef struct packed {
    logic [7:0] code_byte;
    logic       last;
    logic       error;
  } word_t;

  function automatic idx_t low_bit(input idx_t x);
    low_bit = x & (~x + idx_t'(1));
  endfunction

  // Count held by a tree node when every value is present.
  function automatic cnt_t init_cnt(input addr_t a);
    idx_t node;
    node     = idx_t'(a) + idx_t'(1);
    init_cnt = cnt_t'(low_bit(node));
  endfunction

endpackage

@@ rtl/core/lehmer_permutation_encoder.sv @@
// ----------------------------------------------------------------------------
// Lehmer permutation encoder
// Emits the Lehmer rank of each permutation element as LEB128 varint words.
// ----------------------------------------------------------------------------
// Before its first output word an element walks q + u Fenwick nodes, where
// q is the number of nodes read by the prefix query and u the number of
// nodes that the removal updates after its first one, which is written while
// the used flag is checked. With 4096 values q + u is always 12, and never
// more for a smaller size; an element in error skips the walks. All nodes
// live in one 4096-entry memory with one read and one write port; the walks
// issue one read per cycle. Each word carries an epoch mark, so a new
// permutation needs no clearing, except that after reset, and on every 256th
// permutation start when the epoch wraps, a clearing pass over all 4096 words
// runs before the element is encoded. A new perm_size takes effect at the
// next element with first set. Up to two output words are buffered, so the
// next element is accepted while results are still waiting.
module lehmer_permutation_encoder (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [lpe_pkg::CFG_W-1:0] perm_size,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [11:0]               element,
  input  logic                      first,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [7:0]                code_byte,
  output logic                      last,
  output logic                      error
);
  import lpe_pkg::*;

  typedef enum logic [2:0] {
    S_SWEEP,
    S_IDLE,
    S_DECIDE,
    S_CHECK,
    S_WALK,
    S_FIN
  } state_t;

  state_t            state;
  logic [CFG_W-1:0]  size_cfg;
  cnt_t              act_size;
  epoch_t            epoch;
  logic              err_latched;
  addr_t             sweep_cnt;
  logic              resume;
  addr_t             elem;
  logic              pend_valid;
  logic              pend_query;
  addr_t             pend_addr;
  addr_t             qv;
  idx_t              ui;
  addr_t             rank;
  logic              res_err;
  logic [1:0]        ob_cnt;
  word_t             ob0;
  word_t             ob1;

  ent_t              mem [MAX_ELEMENTS];
  ent_t              rd_data;
  addr_t             rd_addr;
  logic              we;
  addr_t             wa;
  ent_t              wd;
  addr_t             ra;

  logic              rd_hit;
  logic              rd_used;
  cnt_t              rd_cnt;
  logic              q_go;
  logic              u_go;
  logic              issue;
  addr_t             walk_addr;
  idx_t              node1;
  logic              bad;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (ob_cnt != 2'd0);
  assign code_byte = ob0.code_byte;
  assign last      = ob0.last;
  assign error     = ob0.error;

  // A word from an older epoch reads as its all-present value.
  always_comb begin
    rd_hit  = (rd_data.epoch == epoch);
    rd_used = rd_hit & rd_data.used;
    rd_cnt  = rd_hit ? rd_data.cnt : init_cnt(rd_addr);
  end

  always_comb begin
    q_go      = (qv != addr_t'(0));
    u_go      = !q_go && (ui <= idx_t'(act_size));
    issue     = (state == S_WALK) && (q_go || u_go);
    walk_addr = q_go ? (qv - addr_t'(1)) : addr_t'(ui - idx_t'(1));
    node1     = idx_t'(elem) + idx_t'(1);
    bad       = err_latched || (cnt_t'(elem) >= act_size);
  end

  always_comb begin
    we = 1'b0;
    wa = elem;
    wd = '{epoch: epoch, used: 1'b1, cnt: rd_cnt - cnt_t'(1)};
    ra = elem;
    case (state)
      S_SWEEP: begin
        we = 1'b1;
        wa = sweep_cnt;
        wd = '{epoch: '0, used: 1'b0, cnt: init_cnt(sweep_cnt)};
      end
      S_CHECK: begin
        // Removal starts at node elem + 1, which shares the word of the used flag.
        we = !rd_used;
      end
      S_WALK: begin
        ra = walk_addr;
        if (pend_valid && !pend_query) begin
          we = 1'b1;
          wa = pend_addr;
          wd = '{epoch: epoch, used: rd_used, cnt: rd_cnt - cnt_t'(1)};
        end
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    rd_data <= mem[ra];
    rd_addr <= ra;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_SWEEP;
      size_cfg    <= CFG_W'(MAX_ELEMENTS);
      act_size    <= cnt_t'(MAX_ELEMENTS);
      epoch       <= '0;
      err_latched <= 1'b0;
      sweep_cnt   <= '0;
      resume      <= 1'b0;
      pend_valid  <= 1'b0;
      ob_cnt      <= 2'd0;
    end else begin
      if (cfg_we) begin
        size_cfg <= perm_size;
      end

      if (out_valid && out_ready) begin
        ob0    <= ob1;
        ob_cnt <= ob_cnt - 2'd1;
      end

      case (state)
        S_SWEEP: begin
          sweep_cnt <= sweep_cnt + addr_t'(1);
          if (sweep_cnt == '1) begin
            state <= resume ? S_DECIDE : S_IDLE;
          end
        end

        S_IDLE: begin
          if (in_valid) begin
            elem   <= element;
            resume <= 1'b1;
            state  <= S_DECIDE;
            if (first) begin
              act_size    <= (size_cfg > CFG_W'(MAX_ELEMENTS)) ? cnt_t'(MAX_ELEMENTS)
                                                               : cnt_t'(size_cfg);
              err_latched <= 1'b0;
              if (epoch == '1) begin
                epoch     <= '0;
                sweep_cnt <= '0;
                state     <= S_SWEEP;
              end else begin
                epoch <= epoch + epoch_t'(1);
              end
            end
          end
        end

        S_DECIDE: begin
          if (bad) begin
            res_err     <= 1'b1;
            err_latched <= 1'b1;
            state       <= S_FIN;
          end else begin
            state <= S_CHECK;
          end
        end

        S_CHECK: begin
          if (rd_used) begin
            res_err     <= 1'b1;
            err_latched <= 1'b1;
            state       <= S_FIN;
          end else begin
            res_err    <= 1'b0;
            rank       <= '0;
            qv         <= elem;
            ui         <= node1 + low_bit(node1);
            pend_valid <= 1'b0;
            state      <= S_WALK;
          end
        end

        S_WALK: begin
          if (issue) begin
            pend_valid <= 1'b1;
            pend_query <= q_go;
            pend_addr  <= walk_addr;
            if (q_go) begin
              qv <= qv & (qv - addr_t'(1));
            end else begin
              ui <= ui + low_bit(ui);
            end
          end else begin
            pend_valid <= 1'b0;
            if (!pend_valid) begin
              state <= S_FIN;
            end
          end
          if (pend_valid && pend_query) begin
            rank <= rank + rd_cnt[ADDR_W-1:0];
          end
        end

        S_FIN: begin
          if (ob_cnt == 2'd0) begin
            state <= S_IDLE;
            if (res_err) begin
              ob0    <= '{code_byte: 8'h00, last: 1'b1, error: 1'b1};
              ob_cnt <= 2'd1;
            end else if (rank >= addr_t'(VARINT_CONT)) begin
              ob0    <= '{code_byte: VARINT_CONT | {1'b0, rank[6:0] & VARINT_LOW7},
                          last: 1'b0, error: 1'b0};
              ob1    <= '{code_byte: 8'(rank >> 7), last: 1'b1, error: 1'b0};
              ob_cnt <= 2'd2;
            end else begin
              ob0    <= '{code_byte: 8'(rank), last: 1'b1, error: 1'b0};
              ob_cnt <= 2'd1;
            end
          end
        end

        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ test/lpe_rank_checker.sv @@
// ----------------------------------------------------------------------------
// Lehmer permutation encoder rank checker
// Watches the configuration port and both word channels, and predicts the
// varint words of every accepted element from its own copy of the used
// values. Each output word is compared with the oldest prediction.
// ----------------------------------------------------------------------------
module lpe_rank_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_we,
  input  logic [lpe_pkg::CFG_W-1:0] perm_size,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [11:0]               element,
  input  logic                      first,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [7:0]                code_byte,
  input  logic                      last,
  input  logic                      error,
  output int                        mismatches,
  output int                        pending
);

  localparam logic [lpe_pkg::CFG_W-1:0] SIZE_AT_RESET = 13'd4096;

  lpe_pkg::word_t                   rank_words_q[$];
  logic [lpe_pkg::CFG_W-1:0]        size_reg;
  int unsigned                      live_size;
  logic [lpe_pkg::MAX_ELEMENTS-1:0] taken;
  logic                             err_latched;
  int                               bad;

  task automatic push_word(input logic [7:0] b, input logic l, input logic e);
    lpe_pkg::word_t w;
    w.code_byte = b;
    w.last      = l;
    w.error     = e;
    rank_words_q.insert(rank_words_q.size(), w);
  endtask

  // The rank is the element minus the number of used values below it.
  task automatic rank_element(input logic [11:0] e, input logic f);
    int below;
    int rank;
    if (f) begin
      live_size   = (size_reg > lpe_pkg::MAX_ELEMENTS) ? lpe_pkg::MAX_ELEMENTS : size_reg;
      taken       = '0;
      err_latched = 1'b0;
    end
    if (err_latched || e >= live_size || taken[e]) begin
      err_latched = 1'b1;
      push_word(8'h00, 1'b1, 1'b1);
    end else begin
      below = 0;
      for (int i = 0; i < e; i++)
        if (taken[i])
          below++;
      rank     = int'(e) - below;
      taken[e] = 1'b1;
      if (rank >= lpe_pkg::VARINT_CONT) begin
        push_word({1'b1, rank[6:0]}, 1'b0, 1'b0);
        rank = rank >> 7;
      end
      push_word(rank[7:0], 1'b1, 1'b0);
    end
  endtask

  always @(posedge clk) begin : watch
    lpe_pkg::word_t want;
    if (rst) begin
      rank_words_q.delete();
      size_reg    = SIZE_AT_RESET;
      live_size   = lpe_pkg::MAX_ELEMENTS;
      taken       = '0;
      err_latched = 1'b0;
      bad         = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (rank_words_q.size() == 0) begin
          bad++;
          if (bad <= 10)
            $display("unexpected word: code_byte=%h last=%b error=%b",
                     code_byte, last, error);
        end else begin
          want = rank_words_q.pop_front();
          if (want.code_byte !== code_byte || want.last !== last || want.error !== error) begin
            bad++;
            if (bad <= 10)
              $display("word mismatch: expected code_byte=%h last=%b error=%b, got %h %b %b",
                       want.code_byte, want.last, want.error, code_byte, last, error);
          end
        end
      end
      if (cfg_we)
        size_reg = perm_size;
      if (in_valid && in_ready)
        rank_element(element, first);
    end
    mismatches <= bad;
    pending    <= rank_words_q.size();
  end

endmodule

@@ test/tb_lehmer_permutation_encoder.sv @@
// ----------------------------------------------------------------------------
// Lehmer permutation encoder testbench
// Directed elements for the edge cases, then random permutations, restart
// storms and noise over a range of sizes, with random idling on both sides
// and long output stalls. The rank checker does all the comparing.
// ----------------------------------------------------------------------------
module tb_lehmer_permutation_encoder;

  logic                      clk;
  logic                      rst       = 1'b1;
  logic                      cfg_we    = 1'b0;
  logic [lpe_pkg::CFG_W-1:0] perm_size = '0;
  logic                      in_valid  = 1'b0;
  logic [11:0]               element   = '0;
  logic                      first     = 1'b0;
  logic                      out_ready = 1'b0;
  logic                      in_ready;
  logic                      out_valid;
  logic [7:0]                code_byte;
  logic                      last;
  logic                      error;
  int                        mismatches;
  int                        pending;
  int                        items_sent = 0;
  int                        size_now   = 4096;
  int                        order[lpe_pkg::MAX_ELEMENTS];
  logic                      no_idle;

  // A stretch of the run where neither side idles.
  assign no_idle = (items_sent >= 600) && (items_sent < 800);

  lehmer_permutation_encoder dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .perm_size (perm_size),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .element   (element),
    .first     (first),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .code_byte (code_byte),
    .last      (last),
    .error     (error)
  );

  lpe_rank_checker rank_check (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .perm_size  (perm_size),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .element    (element),
    .first      (first),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .code_byte  (code_byte),
    .last       (last),
    .error      (error),
    .mismatches (mismatches),
    .pending    (pending)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(8 * 1000000);
    $display("tb_lehmer_permutation_encoder NOT OK");
    $finish;
  end

  task automatic send_word(input logic [11:0] e, input logic f);
    while (!no_idle && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    element  <= e;
    first    <= f;
    @(posedge clk);
    while (!in_ready)
      @(posedge clk);
    items_sent++;
  endtask

  // Lets every predicted word arrive, then gives the block time to settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0)
      @(posedge clk);
    repeat (64) @(posedge clk);
  endtask

  task automatic set_size(input int n);
    drain();
    cfg_we    <= 1'b1;
    perm_size <= n[12:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    size_now = (n > lpe_pkg::MAX_ELEMENTS) ? lpe_pkg::MAX_ELEMENTS : n;
  endtask

  // Receiver: random stalls, plus two long hold-offs so that the block fills.
  initial begin : receiver
    int hold;
    int holds_done;
    hold       = 0;
    holds_done = 0;
    forever begin
      @(posedge clk);
      if (hold > 0) begin
        out_ready <= 1'b0;
        hold--;
      end else if (!rst && holds_done < 2 && items_sent >= 300 + 600 * holds_done) begin
        out_ready <= 1'b0;
        hold = 400;
        holds_done++;
      end else if (no_idle) begin
        out_ready <= 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= 35);
      end
    end
  end

  initial begin : stimulus
    int          r;
    int          n;
    int          len;
    int          pick;
    int          j;
    int          tmp;
    int          k;
    logic        f;
    logic [11:0] e;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // No first after reset behaves as a permutation of the full size.
    send_word(12'd0, 1'b0);
    send_word(12'd4095, 1'b0);
    send_word(12'd128, 1'b0);
    send_word(12'd1000, 1'b0);
    send_word(12'd1000, 1'b0);
    send_word(12'd3, 1'b0);
    // A first element clears the latched error; ranks either side of 128.
    send_word(12'd4095, 1'b1);
    send_word(12'd128, 1'b1);
    send_word(12'd127, 1'b0);
    send_word(12'd2048, 1'b0);
    set_size(0);
    send_word(12'd0, 1'b1);
    send_word(12'd0, 1'b0);
    set_size(1);
    send_word(12'd0, 1'b1);
    send_word(12'd0, 1'b0);
    set_size(8191);
    send_word(12'd4095, 1'b1);
    // The new size must wait for the next first element.
    set_size(5);
    send_word(12'd10, 1'b0);
    send_word(12'd5, 1'b1);
    send_word(12'd4, 1'b1);
    send_word(12'd0, 1'b0);
    send_word(12'd1, 1'b0);
    send_word(12'd2, 1'b0);
    send_word(12'd3, 1'b0);
    send_word(12'd0, 1'b0);
    set_size(4096);

    while (items_sent < 1350) begin
      if ($urandom_range(99) < 40) begin
        pick = $urandom_range(99);
        if (pick < 45)
          n = $urandom_range(1, 8);
        else if (pick < 70)
          n = $urandom_range(9, 64);
        else if (pick < 82)
          n = $urandom_range(65, 600);
        else if (pick < 92)
          n = 4096;
        else if (pick < 96)
          n = 0;
        else
          n = $urandom_range(4097, 8191);
        set_size(n);
      end
      r = $urandom_range(99);
      if (r < 10 && size_now > 0) begin
        // Many permutation starts in a row, to take the epoch round its wrap.
        repeat (20) send_word(12'($urandom_range((size_now > 4095) ? 4095 : size_now)), 1'b1);
      end else if (r < 20 || size_now == 0) begin
        repeat (15) send_word(12'($urandom_range(4095)), $urandom_range(9) == 0);
      end else begin
        if (size_now <= 64)
          len = size_now + (($urandom_range(99) < 15) ? $urandom_range(1, 3) : 0);
        else
          len = $urandom_range(8, 40);
        for (k = 0; k < size_now; k++)
          order[k] = k;
        for (k = 0; k < len; k++) begin
          if (k < size_now) begin
            j        = $urandom_range(size_now - 1, k);
            tmp      = order[k];
            order[k] = order[j];
            order[j] = tmp;
            e        = 12'(order[k]);
          end else begin
            // Past the end of the permutation every value repeats.
            e = 12'($urandom_range(size_now - 1));
          end
          f = (k == 0) && ($urandom_range(99) >= 15);
          if ($urandom_range(99) < 5)
            e = 12'($urandom_range(4095));
          if (k > 0 && $urandom_range(99) < 3)
            f = 1'b1;
          send_word(e, f);
        end
      end
    end

    drain();
    if (mismatches == 0)
      $display("tb_lehmer_permutation_encoder OK");
    else
      $display("tb_lehmer_permutation_encoder NOT OK");
    $finish;
  end

endmodule
